// ===== rtl/pevc_pkg.sv =====
`default_nettype none

package pevc_pkg;

    localparam int unsigned INDEX_W   = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_DATA_W-1:0] PHASE_MS_RESET = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CONNECT_J    = 3'd0,
        REG_DISCONNECT_J = 3'd1,
        REG_CONNECT_K    = 3'd2,
        REG_DISCONNECT_K = 3'd3,
        REG_TEST_START   = 3'd4,
        REG_TEST_STOP    = 3'd5,
        REG_PHASE_MS     = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        CONN_NONE = 2'd0,
        CONN_J    = 2'd1,
        CONN_K    = 2'd2
    } t_conn;

    typedef enum logic [1:0] {
        PH_J_ON  = 2'd0,
        PH_J_OFF = 2'd1,
        PH_K_ON  = 2'd2,
        PH_K_OFF = 2'd3
    } t_phase;

    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    typedef struct packed {
        logic [INDEX_W-1:0]    idx_conn_j;
        logic [INDEX_W-1:0]    idx_disc_j;
        logic [INDEX_W-1:0]    idx_conn_k;
        logic [INDEX_W-1:0]    idx_disc_k;
        logic [INDEX_W-1:0]    test_start;
        logic [INDEX_W-1:0]    test_stop;
        logic [CFG_DATA_W-1:0] phase_ms;
    } t_cfg;

    typedef struct packed {
        logic  drive_j;
        logic  drive_k;
        t_conn conn_state;
        logic  in_test;
        logic  index_known;
        logic  matches_state;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/pevc_if.sv =====
`default_nettype none

interface pevc_in_if;
    import pevc_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [INDEX_W-1:0] event_index;

    modport source (output valid, output op, output event_index, input ready);
    modport sink   (input valid, input op, input event_index, output ready);
endinterface

interface pevc_out_if;
    logic       valid;
    logic       ready;
    logic       drive_j;
    logic       drive_k;
    logic [1:0] conn_state;
    logic       in_test;
    logic       index_known;
    logic       matches_state;

    modport source (
        output valid, output drive_j, output drive_k, output conn_state,
        output in_test, output index_known, output matches_state, input ready
    );
    modport sink (
        input valid, input drive_j, input drive_k, input conn_state,
        input in_test, input index_known, input matches_state, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/pevc_cfg.sv =====
`default_nettype none

module pevc_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [pevc_pkg::CFG_IDX_W-1:0]   i_idx,
    input  wire logic [pevc_pkg::CFG_DATA_W-1:0]  i_data,
    output pevc_pkg::t_cfg                        o_cfg
);
    import pevc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idx_conn_j <= '0;
            r_cfg.idx_disc_j <= '0;
            r_cfg.idx_conn_k <= '0;
            r_cfg.idx_disc_k <= '0;
            r_cfg.test_start <= '0;
            r_cfg.test_stop  <= '0;
            r_cfg.phase_ms   <= PHASE_MS_RESET;
        end else if (i_we) begin
            case (t_reg_idx'(i_idx))
                REG_CONNECT_J:    r_cfg.idx_conn_j <= i_data;
                REG_DISCONNECT_J: r_cfg.idx_disc_j <= i_data;
                REG_CONNECT_K:    r_cfg.idx_conn_k <= i_data;
                REG_DISCONNECT_K: r_cfg.idx_disc_k <= i_data;
                REG_TEST_START:   r_cfg.test_start <= i_data;
                REG_TEST_STOP:    r_cfg.test_stop  <= i_data;
                REG_PHASE_MS:     r_cfg.phase_ms   <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/pevc_core.sv =====
`default_nettype none

module pevc_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_op,
    input  wire logic [pevc_pkg::INDEX_W-1:0]  i_event_index,
    input  wire pevc_pkg::t_cfg                i_cfg,
    output pevc_pkg::t_result                  o_res
);
    import pevc_pkg::*;

    t_conn                 r_conn,       n_conn;
    logic                  r_out_j,      n_out_j;
    logic                  r_out_k,      n_out_k;
    logic                  r_test_on,    n_test_on;
    t_phase                r_phase,      n_phase;
    logic [CFG_DATA_W-1:0] r_ticks_left, n_ticks_left;

    logic eq_cj, eq_dj, eq_ck, eq_dk, eq_start, eq_stop;
    logic known, agrees;

    assign eq_cj    = (i_event_index == i_cfg.idx_conn_j);
    assign eq_dj    = (i_event_index == i_cfg.idx_disc_j);
    assign eq_ck    = (i_event_index == i_cfg.idx_conn_k);
    assign eq_dk    = (i_event_index == i_cfg.idx_disc_k);
    assign eq_start = (i_event_index == i_cfg.test_start);
    assign eq_stop  = (i_event_index == i_cfg.test_stop);

    always_comb begin
        n_conn       = r_conn;
        n_out_j      = r_out_j;
        n_out_k      = r_out_k;
        n_test_on    = r_test_on;
        n_phase      = r_phase;
        n_ticks_left = r_ticks_left;
        known        = 1'b0;
        agrees       = 1'b0;

        if (i_op == OP_EVENT) begin
            known = eq_cj | eq_dj | eq_ck | eq_dk | eq_start | eq_stop;
            if (eq_cj) begin
                agrees = (r_conn == CONN_J);
            end else if (eq_ck) begin
                agrees = (r_conn == CONN_K);
            end else if (eq_dj || eq_dk) begin
                agrees = (r_conn == CONN_NONE);
            end

            if (eq_start) begin
                n_out_j      = 1'b0;
                n_out_k      = 1'b0;
                n_phase      = PH_J_ON;
                n_ticks_left = '0;
                n_test_on    = 1'b1;
            end
            if (eq_stop) begin
                n_out_j   = 1'b0;
                n_out_k   = 1'b0;
                n_test_on = 1'b0;
            end
            // Normal matching only applies once test mode is off after this word.
            if (!n_test_on) begin
                if (eq_cj) begin
                    n_out_j = 1'b1;
                    n_out_k = 1'b0;
                    n_conn  = CONN_J;
                end else if (eq_ck) begin
                    n_out_j = 1'b0;
                    n_out_k = 1'b1;
                    n_conn  = CONN_K;
                end else if (eq_dj || eq_dk) begin
                    n_out_j = 1'b0;
                    n_out_k = 1'b0;
                    n_conn  = CONN_NONE;
                end
            end
        end else if (r_test_on) begin
            if (r_ticks_left != '0) begin
                n_ticks_left = r_ticks_left - 1'b1;
            end else begin
                case (r_phase)
                    PH_J_ON: begin
                        n_out_j = 1'b1;
                        n_out_k = 1'b0;
                    end
                    PH_K_ON: begin
                        n_out_j = 1'b0;
                        n_out_k = 1'b1;
                    end
                    default: begin
                        n_out_j = 1'b0;
                        n_out_k = 1'b0;
                    end
                endcase
                n_phase = t_phase'(r_phase + 2'd1);
                // A zero phase length behaves as one tick per phase.
                n_ticks_left = (i_cfg.phase_ms == '0) ? '0 : i_cfg.phase_ms - 1'b1;
            end
        end

        o_res.drive_j       = n_out_j;
        o_res.drive_k       = n_out_k;
        o_res.conn_state    = n_conn;
        o_res.in_test       = n_test_on;
        o_res.index_known   = known;
        o_res.matches_state = agrees;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn       <= CONN_NONE;
            r_out_j      <= 1'b0;
            r_out_k      <= 1'b0;
            r_test_on    <= 1'b0;
            r_phase      <= PH_J_ON;
            r_ticks_left <= '0;
        end else if (i_en) begin
            r_conn       <= n_conn;
            r_out_j      <= n_out_j;
            r_out_k      <= n_out_k;
            r_test_on    <= n_test_on;
            r_phase      <= n_phase;
            r_ticks_left <= n_ticks_left;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/frog_polarity_event_controller_unit.sv =====
// Channel  Port    Dir  Fields
// -------  ------  ---  ------------------------------------------------------
// input    i_in    in   op, event_index
// output   o_out   out  drive_j, drive_k, conn_state, in_test, index_known,
//                       matches_state
// config   i_cfg_* in   i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// One word is taken every cycle unless i_in.ready is low. A word is held in the input
// register, then its result is computed and loaded into the output register, where
// o_out.valid rises and the result waits until it is taken. Reset is synchronous
// and active low; it clears all control state and loads the register defaults.
// A stalled output register stalls the input register, and i_in.ready falls
// only when both hold a word and o_out.ready is low.
`default_nettype none

module frog_polarity_event_controller_unit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pevc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pevc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pevc_in_if.sink                              i_in,
    pevc_out_if.source                           o_out
);
    import pevc_pkg::*;

    t_cfg    w_cfg;
    t_result w_res;

    logic               r_in_valid;
    logic               r_in_op;
    logic [INDEX_W-1:0] r_in_index;
    logic               r_out_valid;
    t_result            r_out;

    logic advance;
    logic in_ready;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign in_ready = !r_in_valid || advance;

    pevc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    pevc_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_op          (r_in_op),
        .i_event_index (r_in_index),
        .i_cfg         (w_cfg),
        .o_res         (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_op    <= i_in.op;
            r_in_index <= i_in.event_index;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= w_res;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_out_valid;
    assign o_out.drive_j       = r_out.drive_j;
    assign o_out.drive_k       = r_out.drive_k;
    assign o_out.conn_state    = r_out.conn_state;
    assign o_out.in_test       = r_out.in_test;
    assign o_out.index_known   = r_out.index_known;
    assign o_out.matches_state = r_out.matches_state;

`ifndef SYNTH
    // J and K must never be driven together.
    a_drive_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.drive_j && r_out.drive_k))
        else $error("drive_j and drive_k both active");

    // A tick word never reports a known index or a state match.
    a_tick_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in_op == OP_TICK) |=> (!r_out.index_known && !r_out.matches_state))
        else $error("tick result carries event flags");

    // A state match is only possible for a known index.
    a_match_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.matches_state || r_out.index_known))
        else $error("matches_state without index_known");
`endif

endmodule

`default_nettype wire
